// File: hdl/hpbs_pkg.sv
// Shared types, register indexes and constants of the host power button sequencer.
`default_nettype none
package hpbs_pkg;

  // Item kinds carried in the input tuser field
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_STOP    = 2'd2,
    OP_STANDBY = 2'd3
  } op_e;

  // Action that currently holds the lockout
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_STOP    = 2'd2,
    ACT_STANDBY = 2'd3
  } act_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_HOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_HOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STANDBY_PULSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STANDBY_WAIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_LOCKOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LOCKOUT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_CYCLE    = 3'd6;

  // Reset values of the registers
  localparam logic [15:0] RST_BOOT_HOLD     = 16'd2100;
  localparam logic [15:0] RST_SHUTDOWN_HOLD = 16'd5100;
  localparam logic [15:0] RST_STANDBY_PULSE = 16'd100;
  localparam logic [15:0] RST_STANDBY_WAIT  = 16'd5000;
  localparam logic [19:0] RST_START_LOCKOUT = 20'd60000;
  localparam logic [19:0] RST_STOP_LOCKOUT  = 20'd60000;
  localparam logic [15:0] RST_MAIN_CYCLE    = 16'd500;

  // Phase flag bit positions
  localparam int unsigned PH_START = 0;
  localparam int unsigned PH_STOP  = 1;
  localparam int unsigned PH_PULSE = 2;
  localparam int unsigned PH_WAIT  = 3;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [15:0] boot_hold;
    logic [15:0] shutdown_hold;
    logic [15:0] standby_pulse;
    logic [15:0] standby_wait;
    logic [19:0] start_lockout;
    logic [19:0] stop_lockout;
    logic [15:0] main_cycle;
  } cfg_t;

  typedef struct packed {
    op_e  op;
    logic pin;
  } item_t;

  typedef struct packed {
    logic       host_running_seen;
    logic       request_refused;
    logic [1:0] active_action;
    logic       display_button;
    logic       power_button;
  } res_t;

endpackage
`default_nettype wire

// File: hdl/host_power_button_sequencer.sv
// Top level of the host power button sequencer: stream ports, configuration registers.
// A word accepted into the queue passes through the back end into the result register.
// Throughput: one word per cycle sustained; the back end retires one queued word per cycle
//   whenever its result register is empty or being drained.
// A two-word queue parts the input from the back end, so input and output stall on their own.
// Reset (rst_ni low, asynchronous): time and state clear, buttons released, no lockout,
//   host seen off, configuration registers back to their default values.
`default_nettype none
module host_power_button_sequencer
  import hpbs_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [0] host_running_pin, [7:1] zero
  input  wire logic [1:0]            s_axis_tuser,   // [1:0] cmd
  // result stream
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [7:0]            m_axis_tdata,   // [0] power_button, [1] display_button,
                                                     // [3:2] active_action,
                                                     // [4] request_refused,
                                                     // [5] host_running_seen, [7:6] zero
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  item_valid;
  item_t item;
  logic  item_pop;
  res_t  res;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boot_hold     <= RST_BOOT_HOLD;
      cfg_q.shutdown_hold <= RST_SHUTDOWN_HOLD;
      cfg_q.standby_pulse <= RST_STANDBY_PULSE;
      cfg_q.standby_wait  <= RST_STANDBY_WAIT;
      cfg_q.start_lockout <= RST_START_LOCKOUT;
      cfg_q.stop_lockout  <= RST_STOP_LOCKOUT;
      cfg_q.main_cycle    <= RST_MAIN_CYCLE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOOT_HOLD:     cfg_q.boot_hold     <= cfg_data_i[15:0];
        REG_SHUTDOWN_HOLD: cfg_q.shutdown_hold <= cfg_data_i[15:0];
        REG_STANDBY_PULSE: cfg_q.standby_pulse <= cfg_data_i[15:0];
        REG_STANDBY_WAIT:  cfg_q.standby_wait  <= cfg_data_i[15:0];
        REG_START_LOCKOUT: cfg_q.start_lockout <= cfg_data_i;
        REG_STOP_LOCKOUT:  cfg_q.stop_lockout  <= cfg_data_i;
        REG_MAIN_CYCLE:    cfg_q.main_cycle    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Front: classify the word and hold it in the queue
  hpbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_pin_i     (s_axis_tdata[0]),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Back: advance time, run the button sequence, register the result
  hpbs_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {2'b00, res};

`ifndef ASSERT_OFF
  // The display button is only ever pressed together with the power button
  a_display_with_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] || !m_axis_tdata[1]))
    else $error("display button pressed without power button");

  // A pressed button always belongs to a locked action
  a_press_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[3:2] != ACT_NONE))
    else $error("button pressed with no action locked");

  // The queue only fills up after a word was taken in
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input ready dropped without an accepted word");
`endif

endmodule
`default_nettype wire

// File: hdl/hpbs_front.sv
// Front end: accept and classify input words into a short queue for the back end.
`default_nettype none
module hpbs_front
  import hpbs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [1:0] in_cmd_i,
  input  wire logic       in_pin_i,
  output      logic       item_valid_o,
  output      item_t      item_o,
  input  wire logic       item_pop_i
);

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  item_t               mem_q [QDEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push;
  item_t               item_in;

  // Classify the command
  always_comb begin
    item_in.pin = in_pin_i;
    unique case (in_cmd_i)
      OP_START:   item_in.op = OP_START;
      OP_STOP:    item_in.op = OP_STOP;
      OP_STANDBY: item_in.op = OP_STANDBY;
      default:    item_in.op = OP_TICK;
    endcase
  end

  assign in_ready_o   = (count_q != CntW'(QDEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, item_pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hpbs_back.sv
// Back end: timekeeping, button sequencing, lockouts and the registered result stage.
`default_nettype none
module hpbs_back
  import hpbs_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  output      logic  item_pop_o,
  output      logic  res_valid_o,
  input  wire logic  res_ready_i,
  output      res_t  res_o
);

  typedef logic [TIME_BITS-1:0] tm_t;

  function automatic logic elapsed(input tm_t now, input tm_t since, input tm_t span);
    tm_t diff;
    diff = now - since;
    return diff >= span;
  endfunction

  function automatic tm_t ext16(input logic [15:0] v);
    return {{(TIME_BITS-16){1'b0}}, v};
  endfunction

  function automatic tm_t ext20(input logic [19:0] v);
    return {{(TIME_BITS-20){1'b0}}, v};
  endfunction

  tm_t        now_q, now_d, now_n;
  tm_t        hold_q, hold_d;
  tm_t        stby_q, stby_d;
  tm_t        main_q, main_d;
  tm_t        trans_q, trans_d;
  logic [3:0] phase_q, phase_d, phase_t;
  act_e       lock_q, lock_d;
  logic       seen_q, seen_d;
  logic [1:0] btn_q, btn_d;
  logic       res_valid_q;
  res_t       res_q, res_d;

  logic       wait_done, start_done, stop_done, pulse_done, trans_hit;
  logic       stop_el, lock_el;
  tm_t        lock_span;
  logic       refused;

  assign item_pop_o  = item_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign now_n       = now_q + 1'b1;

  // Tick checks, all taken in parallel against the advanced time
  always_comb begin
    wait_done  = phase_q[PH_WAIT] && elapsed(now_n, stby_q, ext16(cfg_i.standby_wait));
    start_done = phase_q[PH_START] && elapsed(now_n, hold_q, ext16(cfg_i.boot_hold));
    // a start release restarts the hold timestamp before the stop check
    stop_el    = start_done ? (cfg_i.shutdown_hold == '0)
                            : elapsed(now_n, hold_q, ext16(cfg_i.shutdown_hold));
    stop_done  = phase_q[PH_STOP] && stop_el;
    pulse_done = phase_q[PH_PULSE] && elapsed(now_n, stby_q, ext16(cfg_i.standby_pulse));
    trans_hit  = wait_done || start_done || stop_done;

    phase_t          = phase_q;
    phase_t[PH_START] = phase_q[PH_START] && !start_done;
    phase_t[PH_STOP]  = phase_q[PH_STOP] && !stop_done;
    phase_t[PH_PULSE] = phase_q[PH_PULSE] && !pulse_done;
    phase_t[PH_WAIT]  = (phase_q[PH_WAIT] && !wait_done) || pulse_done;

    case (lock_q)
      ACT_START:   lock_span = ext20(cfg_i.start_lockout);
      ACT_STOP:    lock_span = ext20(cfg_i.stop_lockout);
      ACT_STANDBY: lock_span = ext16(cfg_i.standby_wait);
      default:     lock_span = '0;
    endcase
    lock_el = trans_hit ? (lock_span == '0) : elapsed(now_n, trans_q, lock_span);
  end

  always_comb begin
    now_d   = now_q;
    hold_d  = hold_q;
    stby_d  = stby_q;
    main_d  = main_q;
    trans_d = trans_q;
    phase_d = phase_q;
    lock_d  = lock_q;
    seen_d  = seen_q;
    btn_d   = btn_q;
    refused = 1'b0;

    if (item_i.op == OP_TICK) begin
      now_d   = now_n;
      phase_d = phase_t;
      if (start_done || stop_done) begin
        hold_d   = now_n;
        btn_d[0] = 1'b0;
      end
      if (trans_hit) begin
        trans_d = now_n;
      end
      if (pulse_done) begin
        btn_d  = 2'b00;
        stby_d = now_n;
      end
      // main cycle: sample host status and release an expired lockout
      if (phase_t == '0 && elapsed(now_n, main_q, ext16(cfg_i.main_cycle))) begin
        seen_d = item_i.pin;
        main_d = now_n;
        if (lock_q != ACT_NONE && lock_el) begin
          lock_d = ACT_NONE;
        end
      end
    end else if (lock_q != ACT_NONE) begin
      refused = 1'b1;
    end else begin
      unique case (item_i.op)
        OP_START: begin
          if (phase_q[PH_START] || seen_q) begin
            refused = 1'b1;
          end else begin
            phase_d[PH_START] = 1'b1;
            lock_d            = ACT_START;
            btn_d[0]          = 1'b1;
            hold_d            = now_q;
          end
        end
        OP_STOP: begin
          if (phase_q[PH_STOP] || !seen_q) begin
            refused = 1'b1;
          end else begin
            phase_d[PH_STOP] = 1'b1;
            lock_d           = ACT_STOP;
            btn_d[0]         = 1'b1;
            hold_d           = now_q;
          end
        end
        default: begin
          if (phase_q[PH_PULSE] || phase_q[PH_WAIT] || !seen_q) begin
            refused = 1'b1;
          end else begin
            phase_d[PH_PULSE] = 1'b1;
            lock_d            = ACT_STANDBY;
            btn_d             = 2'b11;
            stby_d            = now_q;
          end
        end
      endcase
    end

    res_d.power_button      = btn_d[0];
    res_d.display_button    = btn_d[1];
    res_d.active_action     = lock_d;
    res_d.request_refused   = refused;
    res_d.host_running_seen = seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      hold_q      <= '0;
      stby_q      <= '0;
      main_q      <= '0;
      trans_q     <= '0;
      phase_q     <= '0;
      lock_q      <= ACT_NONE;
      seen_q      <= 1'b0;
      btn_q       <= 2'b00;
      res_valid_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        now_q   <= now_d;
        hold_q  <= hold_d;
        stby_q  <= stby_d;
        main_q  <= main_d;
        trans_q <= trans_d;
        phase_q <= phase_d;
        lock_q  <= lock_d;
        seen_q  <= seen_d;
        btn_q   <= btn_d;
      end
      if (item_pop_o) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule
`default_nettype wire

// File: bench/button_board_pkg.sv
// Scoreboard class of the power button sequencer bench: predicts button levels, checks results.
`timescale 1ns / 1ps
package button_board_pkg;
  import hpbs_pkg::*;

  class button_level_board;
    // shadow of the configuration registers
    logic [15:0] boot_hold, shutdown_hold, pulse_len, wait_len, cycle_len;
    logic [19:0] start_lock, stop_lock;
    // shadow of the sequencer state
    logic [31:0] now_cnt, hold_mark, standby_mark, cycle_mark, release_mark;
    logic [3:0]  phase;
    act_e        lock;
    logic        host_seen;
    logic [1:0]  buttons;
    // results still owed by the block
    res_t        levels_due[$];
    int unsigned words_checked, failures;
    int unsigned ticks, granted, refused, pulses;

    function new();
      boot_hold     = RST_BOOT_HOLD;
      shutdown_hold = RST_SHUTDOWN_HOLD;
      pulse_len     = RST_STANDBY_PULSE;
      wait_len      = RST_STANDBY_WAIT;
      start_lock    = RST_START_LOCKOUT;
      stop_lock     = RST_STOP_LOCKOUT;
      cycle_len     = RST_MAIN_CYCLE;
      now_cnt       = '0;
      hold_mark     = '0;
      standby_mark  = '0;
      cycle_mark    = '0;
      release_mark  = '0;
      phase         = '0;
      lock          = ACT_NONE;
      host_seen     = 1'b0;
      buttons       = '0;
      words_checked = 0;
      failures      = 0;
      ticks         = 0;
      granted       = 0;
      refused       = 0;
      pulses        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BOOT_HOLD:     boot_hold = data[15:0];
        REG_SHUTDOWN_HOLD: shutdown_hold = data[15:0];
        REG_STANDBY_PULSE: pulse_len = data[15:0];
        REG_STANDBY_WAIT:  wait_len = data[15:0];
        REG_START_LOCKOUT: start_lock = data;
        REG_STOP_LOCKOUT:  stop_lock = data;
        REG_MAIN_CYCLE:    cycle_len = data[15:0];
        default: ;
      endcase
    endfunction

    // modular compare over the 32-bit time base
    function bit span_done(logic [31:0] since, logic [31:0] span);
      logic [31:0] diff;
      diff = now_cnt - since;
      return diff >= span;
    endfunction

    function void advance_tick(logic pin);
      now_cnt = now_cnt + 32'd1;
      if (phase[PH_WAIT] && span_done(standby_mark, wait_len)) begin
        phase[PH_WAIT] = 1'b0;
        release_mark = now_cnt;
      end
      if (phase[PH_START] && span_done(hold_mark, boot_hold)) begin
        phase[PH_START] = 1'b0;
        hold_mark = now_cnt;
        buttons[0] = 1'b0;
        release_mark = now_cnt;
      end
      if (phase[PH_STOP] && span_done(hold_mark, shutdown_hold)) begin
        phase[PH_STOP] = 1'b0;
        hold_mark = now_cnt;
        buttons[0] = 1'b0;
        release_mark = now_cnt;
      end
      if (phase[PH_PULSE] && span_done(standby_mark, pulse_len)) begin
        phase[PH_PULSE] = 1'b0;
        phase[PH_WAIT] = 1'b1;
        buttons = 2'b00;
        standby_mark = now_cnt;
      end
      // main cycle: sample the host and clear an expired lockout
      if (phase == 4'd0 && span_done(cycle_mark, cycle_len)) begin
        host_seen = pin;
        cycle_mark = now_cnt;
        if ((lock == ACT_STOP && span_done(release_mark, stop_lock)) ||
            (lock == ACT_START && span_done(release_mark, start_lock)) ||
            (lock == ACT_STANDBY && span_done(release_mark, wait_len)))
          lock = ACT_NONE;
      end
    endfunction

    function bit take_request(op_e op);
      if (lock != ACT_NONE) return 1'b0;
      case (op)
        OP_START: begin
          if (phase[PH_START] || host_seen) return 1'b0;
          phase[PH_START] = 1'b1;
          lock = ACT_START;
          buttons[0] = 1'b1;
          hold_mark = now_cnt;
        end
        OP_STOP: begin
          if (phase[PH_STOP] || !host_seen) return 1'b0;
          phase[PH_STOP] = 1'b1;
          lock = ACT_STOP;
          buttons[0] = 1'b1;
          hold_mark = now_cnt;
        end
        default: begin
          if (phase[PH_PULSE] || phase[PH_WAIT] || !host_seen) return 1'b0;
          phase[PH_PULSE] = 1'b1;
          lock = ACT_STANDBY;
          buttons = 2'b11;
          standby_mark = now_cnt;
          pulses++;
        end
      endcase
      return 1'b1;
    endfunction

    // note one accepted input word and queue the levels it must produce
    function void note_word(op_e op, logic pin);
      res_t want;
      logic no;
      no = 1'b0;
      if (op == OP_TICK) begin
        advance_tick(pin);
        ticks++;
      end else begin
        no = !take_request(op);
        if (no) refused++;
        else granted++;
      end
      want.power_button      = buttons[0];
      want.display_button    = buttons[1];
      want.active_action     = lock;
      want.request_refused   = no;
      want.host_running_seen = host_seen;
      levels_due.push_back(want);
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("ERROR: %s", what);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(logic [7:0] word);
      res_t got, want;
      got = res_t'(word[5:0]);
      words_checked++;
      if (levels_due.size() == 0) begin
        report($sformatf("result %0d (%h) arrived with nothing due", words_checked, word));
        return;
      end
      want = levels_due.pop_front();
      if (got.power_button !== want.power_button ||
          got.display_button !== want.display_button ||
          got.active_action !== want.active_action ||
          got.request_refused !== want.request_refused ||
          got.host_running_seen !== want.host_running_seen ||
          word[7:6] !== 2'b00)
        report($sformatf({"result %0d exp/act: power %b/%b display %b/%b action %0d/%0d ",
                          "refused %b/%b seen %b/%b pad 0/%b"}, words_checked,
                         want.power_button, got.power_button,
                         want.display_button, got.display_button,
                         want.active_action, got.active_action,
                         want.request_refused, got.request_refused,
                         want.host_running_seen, got.host_running_seen, word[7:6]));
    endfunction

    function int unsigned due();
      return levels_due.size();
    endfunction

    // count whatever is still owed at the end of the run
    function void close_out();
      if (levels_due.size() != 0)
        report($sformatf("%0d results never arrived", levels_due.size()));
      failures += (levels_due.size() > 1) ? levels_due.size() - 1 : 0;
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
// Top of the power button sequencer bench: clock, reset, stream drivers and the test sequence.
`timescale 1ns / 1ps
module tb_top;
  import hpbs_pkg::*;
  import button_board_pkg::*;

  // one past the last defined register, written once to show it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // cycles to let pass after the last result before touching registers or ending
  localparam int unsigned DRAIN_CYCLES = 8;
  // result count at which the receiver starts its long hold-off
  localparam int unsigned HOLD_OFF_AT = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  // generous bound on the run: ~800 words, plus drains
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // [0] host_running_pin, [7:1] zero
  logic [1:0]            s_tuser;   // [1:0] cmd
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;   // [0] power, [1] display, [3:2] action,
                                    // [4] refused, [5] host seen, [7:6] zero
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  button_level_board board;
  logic              host_level;     // level the modeled host drives on its pin
  int unsigned       cycle_count;
  int unsigned       settings_loaded;

  host_power_button_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bound the run; a hang anywhere ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count, board.due());
    $display("host_power_button_sequencer regression: fail");
    $finish;
  end

  // Check every result word at the edge it is taken.
  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) board.check_word(m_tdata);
  end

  // Receiver: switch among four stall patterns at random, and hold off once for a long
  // stretch so the input queue fills and the block must drop s_axis_tready.
  initial begin : receiver
    int unsigned mode, span, tick_cnt;
    bit          held_off;
    m_tready = 1'b0;
    mode     = 0;
    span     = 0;
    tick_cnt = 0;
    held_off = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_off && board != null && board.words_checked >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = 50;
        end
        span--;
        tick_cnt++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (tick_cnt % 4 != 3);
        endcase
      end
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(op_e op, logic pin);
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, pin};
    do @(posedge clk_i); while (!s_tready);
    board.note_word(op, pin);
  endtask

  // Drop valid for the span given by n, with junk on the command lines.
  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      s_tuser  <= 2'($urandom);
    end
  endtask

  // Stop offering and wait until every owed result is back.
  task automatic settle();
    idle(1);
    while (board.due() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
  endtask

  task automatic close_writes();
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Put random junk in the unused upper bits of a 16-bit register value.
  function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned v);
    logic [3:0] hi;
    hi = 4'($urandom);
    return {hi, v[15:0]};
  endfunction

  // Short times so holds, pulses and lockouts run their full course often.
  task automatic load_short_settings();
    program_reg(REG_BOOT_HOLD, with_noise($urandom_range(1, 8)));
    program_reg(REG_SHUTDOWN_HOLD, with_noise($urandom_range(1, 8)));
    program_reg(REG_STANDBY_PULSE, with_noise($urandom_range(1, 6)));
    program_reg(REG_STANDBY_WAIT, with_noise($urandom_range(0, 6)));
    program_reg(REG_START_LOCKOUT, 20'($urandom_range(0, 20)));
    program_reg(REG_STOP_LOCKOUT, 20'($urandom_range(0, 20)));
    program_reg(REG_MAIN_CYCLE, with_noise($urandom_range(1, 6)));
    close_writes();
  endtask

  task automatic load_uniform_settings(logic [15:0] span, logic [15:0] pause,
                                       logic [19:0] lockout, logic [15:0] cycle);
    program_reg(REG_BOOT_HOLD, 20'(span));
    program_reg(REG_SHUTDOWN_HOLD, 20'(span));
    program_reg(REG_STANDBY_PULSE, 20'(span));
    program_reg(REG_STANDBY_WAIT, 20'(pause));
    program_reg(REG_START_LOCKOUT, lockout);
    program_reg(REG_STOP_LOCKOUT, lockout);
    program_reg(REG_MAIN_CYCLE, 20'(cycle));
    close_writes();
  endtask

  // Random traffic in bursts: mostly ticks carrying the host level, which flips now and then,
  // plus requests of every kind and a little pin noise.
  task automatic run_traffic(int unsigned count);
    int unsigned left, burst, gap;
    op_e         op;
    logic        pin;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 31) == 0) host_level = ~host_level;
        if ($urandom_range(0, 99) < 62) begin
          op  = OP_TICK;
          pin = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : host_level;
        end else begin
          op  = op_e'($urandom_range(1, 3));
          pin = 1'($urandom_range(0, 1));
        end
        send_word(op, pin);
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      idle(gap);
    end
  endtask

  initial begin : sequence_main
    board           = new();
    host_level      = 1'b1;
    settings_loaded = 0;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_TICK;
    cfg_we   = 1'b0;
    cfg_idx  = REG_BOOT_HOLD;
    cfg_data = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: host seen off, so stop and standby are refused and start goes through.
    send_word(OP_STANDBY, 1'b1);
    send_word(OP_STOP, 1'b0);
    send_word(OP_START, 1'b0);
    send_word(OP_START, 1'b1);
    settle();

    // Shorten everything mid-hold; zero standby wait and zero start lockout included.
    program_reg(REG_BOOT_HOLD, 20'd2);
    program_reg(REG_SHUTDOWN_HOLD, 20'd2);
    program_reg(REG_STANDBY_PULSE, 20'd1);
    program_reg(REG_STANDBY_WAIT, 20'd0);
    program_reg(REG_START_LOCKOUT, 20'd0);
    program_reg(REG_STOP_LOCKOUT, 20'd2);
    program_reg(REG_MAIN_CYCLE, 20'd1);
    program_reg(REG_UNUSED, '1);
    close_writes();

    // Release start, sample host on, then stop, standby and a late start.
    repeat (2) send_word(OP_TICK, 1'b1);
    send_word(OP_START, 1'b0);
    send_word(OP_STOP, 1'b1);
    send_word(OP_STANDBY, 1'b1);
    repeat (4) send_word(OP_TICK, 1'b1);
    send_word(OP_STANDBY, 1'b0);
    repeat (6) send_word(OP_TICK, 1'b0);
    send_word(OP_START, 1'b1);
    repeat (3) send_word(OP_TICK, 1'b0);
    settle();

    // Random phases across short, minimum and maximum settings.
    repeat (2) begin
      load_short_settings();
      run_traffic(150);
      settle();
    end
    load_uniform_settings(16'd1, 16'd0, 20'd0, 16'd1);
    run_traffic(120);
    settle();
    load_uniform_settings(16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF);
    run_traffic(40);
    settle();
    repeat (2) begin
      load_short_settings();
      run_traffic(150);
      settle();
    end

    board.close_out();
    $display("covered %0d words: %0d ticks, %0d requests granted, %0d refused",
             board.words_checked, board.ticks, board.granted, board.refused);
    $display("%0d standby pulses over %0d register settings, one %0d-cycle receiver hold-off",
             board.pulses, settings_loaded, HOLD_OFF_CYCLES);
    if (board.failures == 0) begin
      $display("host_power_button_sequencer regression: pass");
    end else begin
      $display("%0d failures", board.failures);
      $display("host_power_button_sequencer regression: fail");
    end
    $finish;
  end

endmodule

// File: host_power_button_sequencer.f
hdl/hpbs_pkg.sv
hdl/hpbs_front.sv
hdl/hpbs_back.sv
hdl/host_power_button_sequencer.sv
bench/button_board_pkg.sv
bench/tb_top.sv
